FILE: sv/tslf_pkg.sv
// ---------------------------------------------------------------------------
// tslf_pkg
// Shared types and byte constants for the text stream line formatter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tslf_pkg;

   localparam int NumberDigits  = 6;
   localparam int CsrIndexWidth = 3;
   localparam int BodyBytes     = 4;
   localparam int BodyIdxWidth  = 2;

   localparam logic [7:0] ByteTab      = 8'h09;
   localparam logic [7:0] ByteLf       = 8'h0A;
   localparam logic [7:0] ByteSpace    = 8'h20;
   localparam logic [7:0] ByteDollar   = 8'h24;
   localparam logic [7:0] ByteDash     = 8'h2D;
   localparam logic [7:0] ByteZero     = 8'h30;
   localparam logic [7:0] ByteQuestion = 8'h3F;
   localparam logic [7:0] ByteCaretOff = 8'h40;
   localparam logic [7:0] ByteI        = 8'h49;
   localparam logic [7:0] ByteM        = 8'h4D;
   localparam logic [7:0] ByteCaret    = 8'h5E;
   localparam logic [7:0] ByteDel      = 8'h7F;
   localparam logic [7:0] ByteCtrlMax  = 8'h1F;
   localparam logic [7:0] LowSevenMask = 8'h7F;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrNumberAll       = 3'd0,
      CsrNumberNonblank  = 3'd1,
      CsrSqueezeBlank    = 3'd2,
      CsrShowEnds        = 3'd3,
      CsrShowTabs        = 3'd4,
      CsrShowNonprinting = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic at_line_start;
      logic prev_line_blank;
   } line_state_type;

endpackage

`default_nettype wire

FILE: sv/tslf_expand.sv
// ---------------------------------------------------------------------------
// tslf_expand
// Expands one text byte into its line number prefix and body bytes and
// computes the next line state and BCD line number.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tslf_expand
   import tslf_pkg::*;
#(
   parameter int NUMBER_DIGITS = NumberDigits,
   localparam int BcdWidth = 4 * NUMBER_DIGITS
) (
   input  req_type                               item,
   input  cfg_type                               cfg,
   input  line_state_type                        line_cur,
   input  logic [BcdWidth-1:0]                   bcd_cur,
   output logic                                  squeezed,
   output logic                                  num_en,
   output logic [NUMBER_DIGITS:0][7:0]           num_bytes,
   output logic [BodyBytes-1:0][7:0]             body_bytes,
   output logic [BodyIdxWidth-1:0]               body_last,
   output line_state_type                        line_next,
   output logic [BcdWidth-1:0]                   bcd_next
);

   localparam logic [BcdWidth-1:0] BcdOne = {{(BcdWidth-1){1'b0}}, 1'b1};

   logic                at_start;
   logic                prev_blank;
   logic [BcdWidth-1:0] bcd_eff;
   logic [BcdWidth-1:0] bcd_bumped;
   logic                all_nines;
   logic                blank;
   logic [7:0]          c;
   logic [7:0]          c_low;

   // new_file restarts tracking before the byte is looked at
   assign at_start   = line_cur.at_line_start | item.new_file;
   assign prev_blank = line_cur.prev_line_blank & ~item.new_file;
   assign bcd_eff    = item.new_file ? BcdOne : bcd_cur;

   assign c     = item.data_byte;
   assign c_low = c & LowSevenMask;
   assign blank = (c == ByteLf);

   assign squeezed = at_start & blank & prev_blank & cfg.squeeze_blank;
   assign num_en   = at_start & ~squeezed &
                     (cfg.number_nonblank ? ~blank : cfg.number_all);

   // a squeezed line is itself blank, so both fields reduce nicely
   assign line_next.at_line_start   = blank;
   assign line_next.prev_line_blank = at_start ? blank : prev_blank;
   assign bcd_next = num_en ? bcd_bumped : bcd_eff;

   // decimal increment, saturating at all nines
   always_comb begin
      logic       carry;
      logic [3:0] d;
      carry      = 1'b1;
      all_nines  = 1'b1;
      bcd_bumped = bcd_eff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = bcd_eff[4*i +: 4];
         if (d != 4'd9) begin
            all_nines = 1'b0;
         end
         if (carry) begin
            if (d >= 4'd9) begin
               bcd_bumped[4*i +: 4] = 4'd0;
            end else begin
               bcd_bumped[4*i +: 4] = d + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all_nines) begin
         bcd_bumped = bcd_eff;
      end
   end

   // right-aligned digits, most significant first, then a tab
   always_comb begin
      logic       seen;
      logic [3:0] d;
      seen = 1'b0;
      for (int p = 0; p < NUMBER_DIGITS; p++) begin
         d = bcd_eff[4*(NUMBER_DIGITS-1-p) +: 4];
         if (d > 4'd9) begin
            d = 4'd9;
         end
         if (d == 4'd0 && !seen && p < NUMBER_DIGITS - 1) begin
            num_bytes[p] = ByteSpace;
         end else begin
            seen = 1'b1;
            num_bytes[p] = ByteZero | {4'd0, d};
         end
      end
      num_bytes[NUMBER_DIGITS] = ByteTab;
   end

   // body: optional dollar or meta/caret prefix, then the final byte
   always_comb begin
      logic [BodyIdxWidth-1:0] idx;
      logic [7:0]              fin;
      idx        = '0;
      fin        = c;
      body_bytes = '{default: ByteSpace};
      if (cfg.show_tabs && c == ByteTab) begin
         body_bytes[0] = ByteCaret;
         idx           = BodyIdxWidth'(1);
         fin           = ByteI;
      end else begin
         if (cfg.show_ends && c == ByteLf) begin
            body_bytes[idx] = ByteDollar;
            idx             = idx + BodyIdxWidth'(1);
         end
         if (cfg.show_nonprinting && c != ByteLf && c != ByteTab) begin
            if (c[7]) begin
               body_bytes[0] = ByteM;
               body_bytes[1] = ByteDash;
               idx           = BodyIdxWidth'(2);
            end
            fin = c_low;
            if (c_low <= ByteCtrlMax) begin
               body_bytes[idx] = ByteCaret;
               idx             = idx + BodyIdxWidth'(1);
               fin             = c_low | ByteCaretOff;
            end else if (c_low == ByteDel) begin
               body_bytes[idx] = ByteCaret;
               idx             = idx + BodyIdxWidth'(1);
               fin             = ByteQuestion;
            end
         end
      end
      body_bytes[idx] = fin;
      body_last       = idx;
   end

endmodule

`default_nettype wire

FILE: sv/text_stream_line_formatter.sv
// ---------------------------------------------------------------------------
// text_stream_line_formatter
// Line formatter for a byte stream: squeezing, numbering and visible forms.
// ---------------------------------------------------------------------------
// One raw text byte enters per req item (data_byte, new_file). Each item
// yields zero or more rsp items, one formatted byte each, with last set on
// the final byte of that input; a squeezed blank line yields none.
// Registers are written through the csr port (valid/ready, always ready).
// The user must write them only while the block is idle; the block
// itself does not enforce it. An accepted item is held in the input
// register and expanded into the output buffer once the buffer is empty
// or finishing its last byte; its first byte is then offered there.
// The buffer sends one byte per cycle while rsp_stall is low, so
// single-byte items flow at one per cycle. A numbered line adds
// NUMBER_DIGITS + 1 prefix bytes (the digits and a tab).
// The input register takes a new item while the buffer still drains.
// Reset clears all but the item and byte registers, sets the line number
// to one and the block to the start of a line. When rsp_stall is high the
// buffer holds its byte and req_stall rises once the input register is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_stream_line_formatter
   import tslf_pkg::*;
#(
   parameter int NUMBER_DIGITS = NumberDigits
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_wdata
);

   localparam int BcdWidth    = 4 * NUMBER_DIGITS;
   localparam int NumIdxWidth = $clog2(NUMBER_DIGITS + 1);
   localparam logic [BcdWidth-1:0]    BcdOne    = {{(BcdWidth-1){1'b0}}, 1'b1};
   localparam logic [NumIdxWidth-1:0] NumIdxTab = NumIdxWidth'(NUMBER_DIGITS);

   cfg_type                     cfg_ff, cfg_in;
   logic                        in_valid_ff, in_valid_in;
   req_type                     in_item_ff, in_item_in;
   line_state_type              line_ff, line_in;
   logic [BcdWidth-1:0]         bcd_ff, bcd_in;
   logic                        buf_valid_ff, buf_valid_in;
   logic                        num_phase_ff, num_phase_in;
   logic [NumIdxWidth-1:0]      num_idx_ff, num_idx_in;
   logic [BodyIdxWidth-1:0]     body_idx_ff, body_idx_in;
   logic [BodyIdxWidth-1:0]     body_last_ff, body_last_in;
   logic [NUMBER_DIGITS:0][7:0] num_bytes_ff, num_bytes_in;
   logic [BodyBytes-1:0][7:0]   body_bytes_ff, body_bytes_in;

   logic                        x_squeezed;
   logic                        x_num_en;
   logic [NUMBER_DIGITS:0][7:0] x_num_bytes;
   logic [BodyBytes-1:0][7:0]   x_body_bytes;
   logic [BodyIdxWidth-1:0]     x_body_last;
   line_state_type              x_line_next;
   logic [BcdWidth-1:0]         x_bcd_next;

   logic advance;
   logic finishing;
   logic consume;
   logic req_take;

   tslf_expand #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_expand (
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .line_cur   (line_ff),
      .bcd_cur    (bcd_ff),
      .squeezed   (x_squeezed),
      .num_en     (x_num_en),
      .num_bytes  (x_num_bytes),
      .body_bytes (x_body_bytes),
      .body_last  (x_body_last),
      .line_next  (x_line_next),
      .bcd_next   (x_bcd_next)
   );

   // output side
   assign rsp_valid         = buf_valid_ff;
   assign rsp_data.out_byte = num_phase_ff ? num_bytes_ff[num_idx_ff]
                                           : body_bytes_ff[body_idx_ff];
   assign rsp_data.last     = ~num_phase_ff & (body_idx_ff == body_last_ff);

   assign advance   = buf_valid_ff & ~rsp_stall;
   assign finishing = advance & rsp_data.last;
   assign consume   = in_valid_ff & (~buf_valid_ff | finishing);

   assign req_stall = in_valid_ff & ~consume;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrNumberAll:       cfg_in.number_all       = csr_wdata;
            CsrNumberNonblank:  cfg_in.number_nonblank  = csr_wdata;
            CsrSqueezeBlank:    cfg_in.squeeze_blank    = csr_wdata;
            CsrShowEnds:        cfg_in.show_ends        = csr_wdata;
            CsrShowTabs:        cfg_in.show_tabs        = csr_wdata;
            CsrShowNonprinting: cfg_in.show_nonprinting = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff & ~consume;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end
   end

   always_comb begin
      line_in       = line_ff;
      bcd_in        = bcd_ff;
      buf_valid_in  = buf_valid_ff;
      num_phase_in  = num_phase_ff;
      num_idx_in    = num_idx_ff;
      body_idx_in   = body_idx_ff;
      body_last_in  = body_last_ff;
      num_bytes_in  = num_bytes_ff;
      body_bytes_in = body_bytes_ff;
      if (consume) begin
         line_in       = x_line_next;
         bcd_in        = x_bcd_next;
         buf_valid_in  = ~x_squeezed;
         num_phase_in  = x_num_en;
         num_idx_in    = '0;
         body_idx_in   = '0;
         body_last_in  = x_body_last;
         num_bytes_in  = x_num_bytes;
         body_bytes_in = x_body_bytes;
      end else if (advance) begin
         if (num_phase_ff) begin
            if (num_idx_ff == NumIdxTab) begin
               num_phase_in = 1'b0;
            end else begin
               num_idx_in = num_idx_ff + NumIdxWidth'(1);
            end
         end else if (finishing) begin
            buf_valid_in = 1'b0;
         end else begin
            body_idx_in = body_idx_ff + BodyIdxWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         line_ff      <= '{at_line_start: 1'b1, prev_line_blank: 1'b0};
         bcd_ff       <= BcdOne;
         buf_valid_ff <= 1'b0;
         num_phase_ff <= 1'b0;
         num_idx_ff   <= '0;
         body_idx_ff  <= '0;
         body_last_ff <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         line_ff      <= line_in;
         bcd_ff       <= bcd_in;
         buf_valid_ff <= buf_valid_in;
         num_phase_ff <= num_phase_in;
         num_idx_ff   <= num_idx_in;
         body_idx_ff  <= body_idx_in;
         body_last_ff <= body_last_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff    <= in_item_in;
      num_bytes_ff  <= num_bytes_in;
      body_bytes_ff <= body_bytes_in;
   end

   // a squeezed line leaves the block at the start of a line
   a_squeeze_keeps_line_start: assert property (@(posedge clock) disable iff (reset)
      consume && x_squeezed |=> line_ff.at_line_start)
      else $error("squeezed item left line start");

   // the bytes of one item come without gaps
   a_item_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      advance && !rsp_data.last |=> rsp_valid)
      else $error("gap inside an item's bytes");

   // input is held back only while the input register is occupied
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && buf_valid_ff)
      else $error("input stalled with room available");

   // last is never flagged on a number prefix byte
   a_last_not_in_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && num_phase_ff |-> !rsp_data.last)
      else $error("last flagged inside number prefix");

endmodule

`default_nettype wire

FILE: tb/sv/line_format_checker.sv
// ---------------------------------------------------------------------------
// line_format_checker
// Watches the formatter's channels, predicts its output bytes and compares.
// ---------------------------------------------------------------------------
// Keeps its own copy of the control bits and the line state, expands every
// accepted input byte into the bytes it should produce and checks each
// accepted output byte against the oldest of them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_format_checker
   import tslf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_wdata,
   output int                       error_count,
   output int                       bytes_owed
);

   localparam logic [4*NumberDigits-1:0] NumberOne = {{(4*NumberDigits-1){1'b0}}, 1'b1};

   cfg_type                     cfg;
   logic                        at_line_start;
   logic                        prev_line_blank;
   logic [4*NumberDigits-1:0]   line_number;
   rsp_type                     owed[$];
   rsp_type                     burst[$];

   function automatic rsp_type plain(input logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.last     = 1'b0;
      return r;
   endfunction

   // bcd increment that sticks at all nines
   function automatic void advance_number();
      logic [4*NumberDigits-1:0] v;
      logic                      carry;
      if (line_number == {NumberDigits{4'h9}}) return;
      v     = line_number;
      carry = 1'b1;
      for (int i = 0; i < NumberDigits && carry; i++) begin
         if (v[4*i +: 4] >= 4'd9) begin
            v[4*i +: 4] = 4'd0;
         end else begin
            v[4*i +: 4] = v[4*i +: 4] + 4'd1;
            carry       = 1'b0;
         end
      end
      line_number = v;
   endfunction

   function automatic void prefix_number();
      logic       seen;
      logic [3:0] d;
      seen = 1'b0;
      for (int i = NumberDigits - 1; i >= 0; i--) begin
         d = line_number[4*i +: 4];
         if (d > 4'd9) d = 4'd9;
         if (d == 4'd0 && !seen && i > 0) begin
            burst.push_back(plain(ByteSpace));
         end else begin
            seen = 1'b1;
            burst.push_back(plain(ByteZero + d));
         end
      end
      burst.push_back(plain(ByteTab));
      advance_number();
   endfunction

   function automatic void format_item(input req_type r);
      logic [7:0] c;
      logic       blank;
      c = r.data_byte;
      burst.delete();
      if (r.new_file) begin
         at_line_start   = 1'b1;
         prev_line_blank = 1'b0;
         line_number     = NumberOne;
      end
      if (at_line_start) begin
         blank = (c == ByteLf);
         // squeezed blank line produces nothing and keeps the line start
         if (blank && prev_line_blank && cfg.squeeze_blank) return;
         prev_line_blank = blank;
         if (cfg.number_nonblank) begin
            if (!blank) prefix_number();
         end else if (cfg.number_all) begin
            prefix_number();
         end
      end
      at_line_start = (c == ByteLf);
      if (cfg.show_tabs && c == ByteTab) begin
         burst.push_back(plain(ByteCaret));
         burst.push_back(plain(ByteI));
      end else begin
         if (cfg.show_ends && c == ByteLf) burst.push_back(plain(ByteDollar));
         if (cfg.show_nonprinting && c != ByteLf && c != ByteTab) begin
            if (c[7]) begin
               burst.push_back(plain(ByteM));
               burst.push_back(plain(ByteDash));
               c = c & LowSevenMask;
            end
            if (c <= ByteCtrlMax) begin
               burst.push_back(plain(ByteCaret));
               c = c + ByteCaretOff;
            end else if (c == ByteDel) begin
               burst.push_back(plain(ByteCaret));
               c = ByteQuestion;
            end
         end
         burst.push_back(plain(c));
      end
      burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) owed.push_back(burst[i]);
   endfunction

   task automatic report_error(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cfg             = '0;
         at_line_start   = 1'b1;
         prev_line_blank = 1'b0;
         line_number     = NumberOne;
         error_count     = 0;
         owed.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrNumberAll:       cfg.number_all       = csr_wdata;
               CsrNumberNonblank:  cfg.number_nonblank  = csr_wdata;
               CsrSqueezeBlank:    cfg.squeeze_blank    = csr_wdata;
               CsrShowEnds:        cfg.show_ends        = csr_wdata;
               CsrShowTabs:        cfg.show_tabs        = csr_wdata;
               CsrShowNonprinting: cfg.show_nonprinting = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) format_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (owed.size() == 0) begin
               report_error($sformatf("byte %h with nothing expected", got.out_byte));
            end else begin
               want = owed.pop_front();
               if (got.out_byte !== want.out_byte)
                  report_error($sformatf("out_byte %h, expected %h",
                                         got.out_byte, want.out_byte));
               if (got.last !== want.last)
                  report_error($sformatf("last %b, expected %b on byte %h",
                                         got.last, want.last, want.out_byte));
            end
         end
      end
      bytes_owed <= owed.size();
   end

endmodule

FILE: tb/sv/text_stream_line_formatter_tb.sv
// ---------------------------------------------------------------------------
// text_stream_line_formatter_tb
// Stimulus and verdict for the text stream line formatter.
// ---------------------------------------------------------------------------
// Runs a short directed stream through the visible forms, squeezing, both
// numbering modes and a mid-line new file, then random text lines and noise
// under several control settings, with random gaps and output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_stream_line_formatter_tb;
   import tslf_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CsrSpareHigh = 3'd7;
   localparam logic [7:0] ByteTilde    = 8'h7E;
   localparam int         SettleCycles = 8;
   localparam int         PhaseItems   = 22;
   localparam int         RunLimitNs   = 400000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic                     csr_wdata;
   int                       error_count;
   int                       bytes_owed;
   logic                     calm = 1'b0;
   int                       hold_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(RunLimitNs);
      $display("Test completed with failures");
      $finish;
   end

   text_stream_line_formatter dut (.*);

   line_format_checker format_check (.*);

   // output side: random hold after every accepted byte
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) hold_left = calm ? 0 : $urandom_range(0, 7);
         else if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0);
      end
   end

   task automatic send_item(input logic [7:0] b, input logic nf);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, new_file: nf};
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every expected byte is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_csr(CsrNumberAll, c.number_all);
      write_csr(CsrNumberNonblank, c.number_nonblank);
      write_csr(CsrSqueezeBlank, c.squeeze_blank);
      write_csr(CsrShowEnds, c.show_ends);
      write_csr(CsrShowTabs, c.show_tabs);
      write_csr(CsrShowNonprinting, c.show_nonprinting);
      // unused indexes must leave the settings alone
      write_csr($urandom_range(0, 1) ? CsrSpareHigh : CsrSpareLow,
                1'($urandom_range(0, 1)));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 9))
         0:       return ByteTab;
         1:       return 8'($urandom_range(0, ByteCtrlMax));
         2:       return ByteDel;
         3:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(ByteSpace, ByteTilde));
      endcase
   endfunction

   // mostly whole lines with random content, some runs of blank lines, some noise
   task automatic run_phase(input int count);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            sent++;
         end else if (kind <= 2) begin
            len = $urandom_range(1, 3);
            repeat (len) send_item(ByteLf, 1'b0);
            sent += len;
         end else begin
            len = $urandom_range(0, 6);
            send_item(text_byte(), $urandom_range(0, 19) == 0);
            repeat (len) send_item(text_byte(), $urandom_range(0, 29) == 0);
            send_item(ByteLf, 1'b0);
            sent += len + 2;
         end
         if ($urandom_range(0, 24) == 0) drain();
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CsrNumberAll;
      csr_wdata <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // visible forms, number every line, squeezing, new file in mid-line
      apply_settings(cfg_type'(6'b101111));
      send_item("a", 1'b0);
      send_item(ByteTab, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(ByteCtrlMax, 1'b0);
      send_item(ByteDel, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h89, 1'b0);
      send_item(8'h8A, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item("b", 1'b0);
      send_item("c", 1'b1);
      send_item(ByteLf, 1'b0);
      drain();

      // both numbering bits: blank lines stay unnumbered
      apply_settings(cfg_type'(6'b110000));
      send_item(ByteLf, 1'b0);
      send_item("q", 1'b0);
      send_item(ByteTab, 1'b0);
      send_item(8'h8A, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item(ByteLf, 1'b0);
      send_item("z", 1'b0);
      send_item(ByteLf, 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         calm = ($urandom_range(0, 3) == 0);
         if (p == 0) apply_settings(cfg_type'(6'b000000));
         else if (p == 1) apply_settings(cfg_type'(6'b111111));
         else apply_settings(cfg_type'(6'($urandom_range(0, 63))));
         run_phase(PhaseItems);
         drain();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/tslf_pkg.sv
sv/tslf_expand.sv
sv/text_stream_line_formatter.sv
tb/sv/line_format_checker.sv
tb/sv/text_stream_line_formatter_tb.sv
